@@ sv/mstb_pkg.sv @@
// package: shared types, field widths and operation codes of the timer bank
`timescale 1ns / 1ps

package mstb_pkg;

    localparam int NUM_SLOTS_DEF = 16;
    localparam int FUNC_W        = 3;
    localparam int SLOT_W        = 4;
    localparam int DUR_W         = 32;
    localparam int STEP_W        = 20;

    localparam logic [FUNC_W-1:0] FN_START_GIVEN = 3'd0;
    localparam logic [FUNC_W-1:0] FN_START_NEW   = 3'd1;
    localparam logic [FUNC_W-1:0] FN_RESET       = 3'd2;
    localparam logic [FUNC_W-1:0] FN_CANCEL      = 3'd3;
    localparam logic [FUNC_W-1:0] FN_TICK        = 3'd4;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [SLOT_W-1:0] timer_slot;
        logic [DUR_W-1:0]  duration;
        logic              loop_enable;
        logic [STEP_W-1:0] time_step;
    } t_in_item;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic              fired;
        logic              last;
    } t_out_item;

    // outcome of one slot update during a tick
    typedef struct packed {
        logic [DUR_W-1:0] elapsed;
        logic             fire;
    } t_eval;

endpackage

@@ sv/multi_slot_timer_bank_unit.sv @@
// top level of the timer bank: control, slot flags, allocator and output register
//
//  channel   direction  handshake                    payload
//  in        input      i_in_valid / o_in_ready      i_in_data  (t_in_item)
//  out       output     o_out_valid / i_out_ready    o_out_data (t_out_item)
//
// start, reset and cancel load their result straight into the
// output register; unused codes give nothing.
// a tick walks the elapsed ram one slot per cycle, read and write-back pipelined,
// except while a fired slot, or the final report, waits on a full output register.
// flags are flip-flops cleared by reset, the rams need no clearing.
// a request is taken only in idle with the output register free or being emptied.
`timescale 1ns / 1ps

module multi_slot_timer_bank_unit #(
    parameter int NUM_SLOTS = mstb_pkg::NUM_SLOTS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  mstb_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output mstb_pkg::t_out_item o_out_data
);

    localparam int IDX_W  = $clog2(NUM_SLOTS);
    localparam int SLOT_W = mstb_pkg::SLOT_W;
    localparam int DUR_W  = mstb_pkg::DUR_W;
    localparam int EXT_W  = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

    typedef enum logic [0:0] {S_IDLE, S_TICK} t_state;

    function automatic logic [SLOT_W-1:0] to_slot(input logic [IDX_W-1:0] idx);
        logic [EXT_W-1:0] e;
        e = EXT_W'(idx);
        return e[SLOT_W-1:0];
    endfunction

    t_state                     r_state, n_state;
    logic [NUM_SLOTS-1:0]       r_active, n_active;
    logic [NUM_SLOTS-1:0]       r_looping, n_looping;
    logic [IDX_W-1:0]           r_next, n_next;
    logic [mstb_pkg::STEP_W-1:0] r_step, n_step;
    logic [IDX_W-1:0]           r_a_idx, n_a_idx;
    logic                       r_a_valid, n_a_valid;
    logic [IDX_W-1:0]           r_b_idx, n_b_idx;
    logic                       r_b_valid, n_b_valid;
    logic [IDX_W-1:0]           r_held_idx, n_held_idx;
    logic                       r_held, n_held;
    logic                       r_out_valid, n_out_valid;
    mstb_pkg::t_out_item        r_out, n_out;

    logic                       out_free;
    logic                       in_acc;
    logic [EXT_W-1:0]           cmd_ext;
    logic [IDX_W-1:0]           cmd_idx;
    logic                       in_range;
    logic                       b_act;
    logic                       b_fire;
    logic                       stall;

    logic                       per_we;
    logic                       el_we;
    logic [IDX_W-1:0]           wr_idx;
    logic [DUR_W-1:0]           el_wdata;
    logic                       rd_en;
    logic [DUR_W-1:0]           per_rdata;
    logic [DUR_W-1:0]           el_rdata;
    mstb_pkg::t_eval            eval;

    mstb_ram #(.WIDTH(DUR_W), .DEPTH(NUM_SLOTS)) u_period_ram (
        .i_clk   (i_clk),
        .i_we    (per_we),
        .i_waddr (wr_idx),
        .i_wdata (i_in_data.duration),
        .i_re    (rd_en),
        .i_raddr (r_a_idx),
        .o_rdata (per_rdata)
    );

    mstb_ram #(.WIDTH(DUR_W), .DEPTH(NUM_SLOTS)) u_elapsed_ram (
        .i_clk   (i_clk),
        .i_we    (el_we),
        .i_waddr (wr_idx),
        .i_wdata (el_wdata),
        .i_re    (rd_en),
        .i_raddr (r_a_idx),
        .o_rdata (el_rdata)
    );

    mstb_tick_eval u_eval (
        .i_elapsed (el_rdata),
        .i_period  (per_rdata),
        .i_step    (r_step),
        .o_eval    (eval)
    );

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && out_free;
    assign in_acc     = i_in_valid && o_in_ready;
    assign cmd_ext    = EXT_W'(i_in_data.timer_slot);
    assign cmd_idx    = cmd_ext[IDX_W-1:0];
    assign in_range   = 32'(i_in_data.timer_slot) < 32'(NUM_SLOTS);
    assign b_act      = r_active[r_b_idx];
    assign b_fire     = r_b_valid && b_act && eval.fire;
    // a second fire with one already held needs the output register
    assign stall      = b_fire && r_held && !out_free;

    always_comb begin
        n_state     = r_state;
        n_active    = r_active;
        n_looping   = r_looping;
        n_next      = r_next;
        n_step      = r_step;
        n_a_idx     = r_a_idx;
        n_a_valid   = r_a_valid;
        n_b_idx     = r_b_idx;
        n_b_valid   = r_b_valid;
        n_held_idx  = r_held_idx;
        n_held      = r_held;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        per_we      = 1'b0;
        el_we       = 1'b0;
        wr_idx      = cmd_idx;
        el_wdata    = '0;
        rd_en       = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_out = '{slot: i_in_data.timer_slot, fired: 1'b0, last: 1'b1};
                    unique case (i_in_data.func)
                        mstb_pkg::FN_START_GIVEN: begin
                            n_out_valid = 1'b1;
                            if (in_range) begin
                                n_active[cmd_idx]  = 1'b1;
                                n_looping[cmd_idx] = i_in_data.loop_enable;
                                per_we             = 1'b1;
                                el_we              = 1'b1;
                            end
                        end
                        mstb_pkg::FN_START_NEW: begin
                            n_out_valid       = 1'b1;
                            n_out.slot        = to_slot(r_next);
                            wr_idx            = r_next;
                            n_active[r_next]  = 1'b1;
                            n_looping[r_next] = i_in_data.loop_enable;
                            per_we            = 1'b1;
                            el_we             = 1'b1;
                            n_next = (r_next == LAST_IDX) ? '0 : r_next + IDX_W'(1);
                        end
                        mstb_pkg::FN_RESET: begin
                            n_out_valid = 1'b1;
                            el_we       = in_range && r_active[cmd_idx];
                        end
                        mstb_pkg::FN_CANCEL: begin
                            n_out_valid = 1'b1;
                            if (in_range) begin
                                n_active[cmd_idx] = 1'b0;
                            end
                        end
                        mstb_pkg::FN_TICK: begin
                            n_state   = S_TICK;
                            n_step    = i_in_data.time_step;
                            n_a_idx   = '0;
                            n_a_valid = 1'b1;
                            n_b_valid = 1'b0;
                            n_held    = 1'b0;
                        end
                        default: ;
                    endcase
                end
            end
            S_TICK: begin
                if (!stall) begin
                    // issue stage
                    if (r_a_valid) begin
                        rd_en     = 1'b1;
                        n_b_valid = 1'b1;
                        n_b_idx   = r_a_idx;
                        n_a_idx   = r_a_idx + IDX_W'(1);
                        n_a_valid = (r_a_idx != LAST_IDX);
                    end else begin
                        n_b_valid = 1'b0;
                    end
                    // write-back stage
                    if (r_b_valid && b_act) begin
                        el_we    = 1'b1;
                        wr_idx   = r_b_idx;
                        el_wdata = eval.elapsed;
                        if (eval.fire) begin
                            if (r_looping[r_b_idx]) begin
                                el_wdata = '0;
                            end else begin
                                n_active[r_b_idx] = 1'b0;
                            end
                            if (r_held) begin
                                n_out_valid = 1'b1;
                                n_out = '{slot: to_slot(r_held_idx), fired: 1'b1, last: 1'b0};
                            end
                            n_held     = 1'b1;
                            n_held_idx = r_b_idx;
                        end
                    end
                end
                // walk done: flush the held fire as the final result
                if (!r_a_valid && !r_b_valid) begin
                    if (!r_held) begin
                        n_state = S_IDLE;
                    end else if (out_free) begin
                        n_out_valid = 1'b1;
                        n_out  = '{slot: to_slot(r_held_idx), fired: 1'b1, last: 1'b1};
                        n_held = 1'b0;
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_step     <= n_step;
        r_a_idx    <= n_a_idx;
        r_b_idx    <= n_b_idx;
        r_held_idx <= n_held_idx;
        r_out      <= n_out;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_active    <= '0;
            r_looping   <= '0;
            r_next      <= '0;
            r_a_valid   <= 1'b0;
            r_b_valid   <= 1'b0;
            r_held      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_active    <= n_active;
            r_looping   <= n_looping;
            r_next      <= n_next;
            r_a_valid   <= n_a_valid;
            r_b_valid   <= n_b_valid;
            r_held      <= n_held;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

@@ sv/mstb_ram.sv @@
// generic single-port-write, single-port-read ram with registered read data
`timescale 1ns / 1ps

module mstb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // read data holds while read enable is low
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/mstb_tick_eval.sv @@
// tick update of one slot: saturating add of the step and expiry compare
`timescale 1ns / 1ps

module mstb_tick_eval (
    input  logic [mstb_pkg::DUR_W-1:0]  i_elapsed,
    input  logic [mstb_pkg::DUR_W-1:0]  i_period,
    input  logic [mstb_pkg::STEP_W-1:0] i_step,
    output mstb_pkg::t_eval             o_eval
);

    logic [mstb_pkg::DUR_W:0]   sum;
    logic [mstb_pkg::DUR_W-1:0] sat;

    always_comb begin
        sum = {1'b0, i_elapsed} + (mstb_pkg::DUR_W + 1)'(i_step);
        // carry out means overflow, clamp to all ones
        sat = sum[mstb_pkg::DUR_W] ? '1 : sum[mstb_pkg::DUR_W-1:0];
        o_eval.elapsed = sat;
        o_eval.fire    = (sat >= i_period);
    end

endmodule

@@ sv/mstb_checker.sv @@
// port-level checker for the timer bank, bound to the top level
`timescale 1ns / 1ps

module mstb_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input mstb_pkg::t_in_item  i_in_data,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input mstb_pkg::t_out_item o_out_data
);

    logic in_acc;
    logic is_cmd;

    assign in_acc = i_in_valid && o_in_ready;
    assign is_cmd = (i_in_data.func == mstb_pkg::FN_START_GIVEN) ||
                    (i_in_data.func == mstb_pkg::FN_START_NEW) ||
                    (i_in_data.func == mstb_pkg::FN_RESET) ||
                    (i_in_data.func == mstb_pkg::FN_CANCEL);

    // a waiting result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result dropped or changed while stalled");

    // a command request gives its single result in the next cycle
    a_cmd_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && is_cmd |=> o_out_valid && !o_out_data.fired && o_out_data.last)
        else $error("command result missing");

    // start of a given slot echoes the slot number
    a_cmd_echo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (i_in_data.func == mstb_pkg::FN_START_GIVEN)
        |=> o_out_data.slot == $past(i_in_data.timer_slot))
        else $error("start result slot mismatch");

    // non-fire results always close their request
    a_plain_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.fired |-> o_out_data.last)
        else $error("command result without last");

endmodule

bind multi_slot_timer_bank_unit mstb_checker u_mstb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
